>>> src/hcd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; imported by every module under src.
package hcd_pkg;

  localparam int SIZE_BITS_DEF = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       closed;
  } out_word_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } in_item_t;

  // Parser result handed to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_item_t;

  typedef enum logic [2:0] {
    PH_CR     = 3'd0,
    PH_LF     = 3'd1,
    PH_HEX    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CLOSED = 3'd5
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> src/http_chunked_decoder_top.sv
// HTTP chunked body decoder, top level. Takes one body byte per word and
// returns payload bytes, then one word with closed set at the end of stream.
// Bytes pass an input and a result register; a new byte is taken every cycle
// unless the output stalls; the phase and chunk size registers update per
// byte. Words with closed set carry out_byte 0; after close
// all input is swallowed without result. Depends on hcd_pkg and submodules.
module http_chunked_decoder_top #(
  parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hcd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hcd_pkg::out_word_t out_word_o
);
  import hcd_pkg::*;

  in_item_t  item;
  res_item_t res;
  logic      advance;

  hcd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  hcd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_i (advance),
    .res_o     (res)
  );

  hcd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> src/hcd_in_stage.sv
// Input register of the chunked decoder: holds one accepted word.
// Depends on hcd_pkg.
module hcd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hcd_pkg::in_word_t in_word_i,
  input  logic              advance_i,
  output hcd_pkg::in_item_t item_o
);
  import hcd_pkg::*;

  logic     in_valid_q;
  in_word_t in_word_q;

  // Held word blocks a new one only when the parser cannot move
  assign in_stall_o = in_valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  assign item_o.valid = in_valid_q;
  assign item_o.word  = in_word_q;

endmodule

>>> src/hcd_parser.sv
// Byte parser of the chunked decoder: phase and chunk size state plus the
// per-byte step logic. Depends on hcd_pkg.
module hcd_parser #(
  parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcd_pkg::in_item_t  item_i,
  input  logic               advance_i,
  output hcd_pkg::res_item_t res_o
);
  import hcd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;

  logic       step;
  logic [7:0] b;
  logic       eoi;
  logic       is_cr;
  logic       is_lf;
  hex_t       hex;
  logic       lf_stage;
  logic       hex_stage;
  logic       rem_zero;
  logic       sat;

  assign step     = item_i.valid && advance_i;
  assign b        = item_i.word.in_byte;
  assign eoi      = item_i.word.end_of_input;
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);
  assign hex      = hex_decode(b);
  assign rem_zero = (rem_q == '0);
  assign sat      = |rem_q[SIZE_BITS-1:SIZE_BITS-4];

  // Optional CR falls through to optional LF, which falls through to hex
  assign lf_stage  = (phase_q == PH_LF) || ((phase_q == PH_CR) && !is_cr);
  assign hex_stage = (phase_q == PH_HEX) || (lf_stage && !is_lf);

  // Next state
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    if (step) begin
      case (phase_q)
        PH_CR, PH_LF, PH_HEX, PH_SKIP, PH_DATA: begin
          if (eoi) begin
            phase_d = PH_CLOSED;
            rem_d   = '0;
          end else if (phase_q == PH_DATA) begin
            rem_d = rem_q - SIZE_BITS'(1);
            if (rem_q == SIZE_BITS'(1)) begin
              phase_d = PH_CR;
            end
          end else if ((phase_q == PH_CR) && is_cr) begin
            phase_d = PH_LF;
          end else if (phase_q == PH_SKIP || (phase_q == PH_HEX && is_lf)) begin
            if (is_lf) begin
              phase_d = rem_zero ? PH_CLOSED : PH_DATA;
            end
          end else if (hex_stage) begin
            if (!hex.valid) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_HEX;
              rem_d   = sat ? '1 : {rem_q[SIZE_BITS-5:0], hex.value};
            end
          end else begin
            // optional LF consumed
            phase_d = PH_HEX;
          end
        end
        default: begin
          phase_d = PH_CLOSED;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res_o.valid         = 1'b0;
    res_o.word.out_byte = 8'd0;
    res_o.word.closed   = 1'b0;
    if (step) begin
      case (phase_q)
        PH_CR, PH_LF, PH_HEX, PH_SKIP, PH_DATA: begin
          if (eoi) begin
            res_o.valid       = 1'b1;
            res_o.word.closed = 1'b1;
          end else if (phase_q == PH_DATA) begin
            res_o.valid         = 1'b1;
            res_o.word.out_byte = b;
          end else if ((phase_q == PH_SKIP || phase_q == PH_HEX) && is_lf && rem_zero) begin
            res_o.valid       = 1'b1;
            res_o.word.closed = 1'b1;
          end
        end
        default: begin
          res_o.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CR;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) |-> !res_o.valid)
    else $error("result produced after stream close");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("data phase with zero bytes remaining");

  a_close_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.word.closed) |=> (phase_q == PH_CLOSED))
    else $error("close word sent but parser not closed");

  a_data_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && phase_q == PH_DATA) |-> res_o.valid)
    else $error("data byte dropped");

endmodule

>>> src/hcd_out_stage.sv
// Output register of the chunked decoder: holds one result word until taken.
// Depends on hcd_pkg.
module hcd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcd_pkg::res_item_t  res_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcd_pkg::out_word_t  out_word_o
);
  import hcd_pkg::*;

  logic      out_valid_q;
  out_word_t out_word_q;

  // Free, or being taken this cycle
  assign advance_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      out_word_q <= res_i.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
